@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ design/ddc_pkg.sv @@
// ----------------------------------------------------------------------------
// ddc_pkg
// Types, register codes and defaults shared by the DDC EDID reader
// ----------------------------------------------------------------------------
package ddc_pkg;

  // parameter defaults
  localparam int MAX_BYTES_DEF   = 256;
  localparam int TIMER_WIDTH_DEF = 16;

  // fixed field widths
  localparam int LEN_W   = 9;
  localparam int DELAY_W = 16;
  localparam int LIMIT_W = 16;
  localparam int ADDR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 3;
  localparam int CDATA_W = 16;

  // register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_READ_LENGTH    = 3'd0;
  localparam logic [IDX_W-1:0] REG_DELAY_TICKS    = 3'd1;
  localparam logic [IDX_W-1:0] REG_STRETCH_LIMIT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEVICE_ADDRESS = 3'd3;
  localparam logic [IDX_W-1:0] REG_START_OFFSET   = 3'd4;

  // register reset values
  localparam logic [LEN_W-1:0]   READ_LENGTH_RST    = 9'd128;
  localparam logic [DELAY_W-1:0] DELAY_TICKS_RST    = 16'd150;
  localparam logic [LIMIT_W-1:0] STRETCH_LIMIT_RST  = 16'h1000;
  localparam logic [ADDR_W-1:0]  DEVICE_ADDRESS_RST = 7'h50;
  localparam logic [BYTE_W-1:0]  START_OFFSET_RST   = 8'h00;

  // named substeps
  localparam logic [2:0] SB_FIRST    = 3'd0;
  localparam logic [2:0] SB_DATA     = 3'd1;
  localparam logic [2:0] SB_BIT_END  = 3'd2;
  localparam logic [2:0] SB_WAIT     = 3'd3;
  localparam logic [2:0] SB_RECV_END = 3'd4;
  localparam logic [2:0] SB_STOP_END = 3'd4;
  localparam logic [2:0] SB_LAST     = 3'd7;

  // sequencer stage
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_WAKE     = 3'd1,
    ST_SEND_W   = 3'd2,
    ST_SEND_OFS = 3'd3,
    ST_RESTART  = 3'd4,
    ST_SEND_R   = 3'd5,
    ST_RECV     = 3'd6,
    ST_STOP     = 3'd7
  } stage_t;

  // configuration register bank
  typedef struct packed {
    logic [LEN_W-1:0]   read_length;
    logic [DELAY_W-1:0] delay_ticks;
    logic [LIMIT_W-1:0] stretch_limit;
    logic [ADDR_W-1:0]  device_address;
    logic [BYTE_W-1:0]  start_offset;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic              busy_res;
    logic              nak_error;
    logic              done_res;
    logic              last_byte;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_data;
    logic              byte_valid;
    logic              sda_low;
    logic              scl_low;
  } res_t;

endpackage

@@ design/ddc_regs.sv @@
// ----------------------------------------------------------------------------
// ddc_regs
// Configuration register bank, written through an index/data channel
// ----------------------------------------------------------------------------
module ddc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [ddc_pkg::IDX_W-1:0]   wr_index,
  input  logic [ddc_pkg::CDATA_W-1:0] wr_data,
  output ddc_pkg::cfg_t               cfg
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.read_length    <= ddc_pkg::READ_LENGTH_RST;
      cfg.delay_ticks    <= ddc_pkg::DELAY_TICKS_RST;
      cfg.stretch_limit  <= ddc_pkg::STRETCH_LIMIT_RST;
      cfg.device_address <= ddc_pkg::DEVICE_ADDRESS_RST;
      cfg.start_offset   <= ddc_pkg::START_OFFSET_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        ddc_pkg::REG_READ_LENGTH:    cfg.read_length    <= wr_data[ddc_pkg::LEN_W-1:0];
        ddc_pkg::REG_DELAY_TICKS:    cfg.delay_ticks    <= wr_data[ddc_pkg::DELAY_W-1:0];
        ddc_pkg::REG_STRETCH_LIMIT:  cfg.stretch_limit  <= wr_data[ddc_pkg::LIMIT_W-1:0];
        ddc_pkg::REG_DEVICE_ADDRESS: cfg.device_address <= wr_data[ddc_pkg::ADDR_W-1:0];
        ddc_pkg::REG_START_OFFSET:   cfg.start_offset   <= wr_data[ddc_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/ddc_seq.sv @@
// ----------------------------------------------------------------------------
// ddc_seq
// I2C bus sequencer: state registers plus one-tick next-state logic
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddc_seq #(
  parameter int MAX_BYTES   = ddc_pkg::MAX_BYTES_DEF,
  parameter int TIMER_WIDTH = ddc_pkg::TIMER_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          action,
  input  logic          scl_in,
  input  logic          sda_in,
  input  ddc_pkg::cfg_t cfg,
  output ddc_pkg::res_t res
);

  localparam int TW  = TIMER_WIDTH;
  localparam int BW  = $clog2(MAX_BYTES + 1);
  localparam int CW  = ((BW > ddc_pkg::LEN_W) ? BW : ddc_pkg::LEN_W) + 1;
  localparam int DW  = ddc_pkg::DELAY_W;
  localparam logic [TW-1:0] TMAX = '1;

  // state
  ddc_pkg::stage_t stage, stage_next;
  logic [2:0]                   sub, sub_next;
  logic [TW-1:0]                phase_timer, phase_next;
  logic [ddc_pkg::LIMIT_W-1:0]  stretch_timer, stretch_next, stretch_inc;
  logic [2:0]                   bit_counter, bit_counter_next;
  logic [BW-1:0]                bytes_done, bytes_done_next;
  logic [ddc_pkg::BYTE_W-1:0]   shift_byte, shift_next;
  logic                         clock_low, clock_low_next;
  logic                         data_low, data_low_next;

  // step decode helpers
  logic                         ent;
  ddc_pkg::stage_t              ent_stage;
  logic [2:0]                   ent_sub;
  logic                         go;
  logic [TW-1:0]                phase_load;
  logic [CW-1:0]                byte_count;
  logic                         last_cur, last_nxt;
  logic [ddc_pkg::BYTE_W-1:0]   send_byte;
  logic                         phase_end;
  logic                         is_send;

  // bytes to read, clamped to one..MAX_BYTES
  always_comb begin
    if (cfg.read_length == '0) begin
      byte_count = CW'(1);
    end else if (CW'(cfg.read_length) > CW'(MAX_BYTES)) begin
      byte_count = CW'(MAX_BYTES);
    end else begin
      byte_count = CW'(cfg.read_length);
    end
  end

  assign last_cur = (CW'(bytes_done) + CW'(1)) >= byte_count;
  assign last_nxt = (CW'(bytes_done_next) + CW'(1)) >= byte_count;

  // phase reload: saturate to timer range, zero acts as one
  always_comb begin
    if (TW < DW && cfg.delay_ticks > DW'(TMAX)) begin
      phase_load = TMAX;
    end else if (cfg.delay_ticks == '0) begin
      phase_load = TW'(1);
    end else begin
      phase_load = TW'(cfg.delay_ticks);
    end
  end

  // byte shifted out in the current send stage
  always_comb begin
    priority if (ent_stage == ddc_pkg::ST_SEND_W) begin
      send_byte = {cfg.device_address, 1'b0};
    end else if (ent_stage == ddc_pkg::ST_SEND_R) begin
      send_byte = {cfg.device_address, 1'b1};
    end else begin
      send_byte = cfg.start_offset;
    end
  end

  assign phase_end   = phase_timer <= TW'(1);
  assign is_send     = stage == ddc_pkg::ST_SEND_W || stage == ddc_pkg::ST_SEND_OFS ||
                       stage == ddc_pkg::ST_SEND_R;
  assign stretch_inc = stretch_timer + ddc_pkg::LIMIT_W'(1);

  // next state for one tick
  always_comb begin : next_state
    stage_next       = stage;
    sub_next         = sub;
    phase_next       = phase_timer;
    stretch_next     = stretch_timer;
    bit_counter_next = bit_counter;
    bytes_done_next  = bytes_done;
    shift_next       = shift_byte;
    clock_low_next   = clock_low;
    data_low_next    = data_low;
    ent              = 1'b0;
    ent_stage        = stage;
    ent_sub          = sub + 3'd1;
    go               = 1'b0;

    if (step) begin
      if (stage == ddc_pkg::ST_IDLE) begin
        // begin a transfer
        if (action) begin
          bytes_done_next  = '0;
          bit_counter_next = 3'd7;
          shift_next       = '0;
          ent              = 1'b1;
          ent_stage        = ddc_pkg::ST_WAKE;
          ent_sub          = ddc_pkg::SB_FIRST;
        end
      end else if (stage == ddc_pkg::ST_RECV && sub == ddc_pkg::SB_WAIT) begin
        // wait for clock high, bounded by the stretch limit
        go = scl_in;
        if (!scl_in) begin
          stretch_next = stretch_inc;
          go           = stretch_inc >= cfg.stretch_limit;
        end
        if (go) begin
          shift_next = shift_byte | (ddc_pkg::BYTE_W'(sda_in) << bit_counter);
          ent        = 1'b1;
          ent_sub    = ddc_pkg::SB_RECV_END;
        end
      end else if (!phase_end) begin
        phase_next = phase_timer - TW'(1);
      end else if (stage == ddc_pkg::ST_WAKE || stage == ddc_pkg::ST_RESTART) begin
        ent = 1'b1;
        if (sub == ddc_pkg::SB_LAST) begin
          bit_counter_next = 3'd7;
          ent_stage = (stage == ddc_pkg::ST_WAKE) ? ddc_pkg::ST_SEND_W : ddc_pkg::ST_SEND_R;
          ent_sub   = ddc_pkg::SB_FIRST;
        end
      end else if (is_send) begin
        if (sub == ddc_pkg::SB_BIT_END) begin
          ent = 1'b1;
          if (bit_counter != 3'd0) begin
            bit_counter_next = bit_counter - 3'd1;
            ent_sub          = ddc_pkg::SB_FIRST;
          end
        end else if (sub == ddc_pkg::SB_LAST) begin
          if (sda_in) begin
            // missing acknowledge: abort without stop
            stage_next     = ddc_pkg::ST_IDLE;
            sub_next       = '0;
            clock_low_next = 1'b0;
            data_low_next  = 1'b0;
          end else begin
            ent = 1'b1;
            priority if (stage == ddc_pkg::ST_SEND_W) begin
              bit_counter_next = 3'd7;
              ent_stage        = ddc_pkg::ST_SEND_OFS;
              ent_sub          = ddc_pkg::SB_FIRST;
            end else if (stage == ddc_pkg::ST_SEND_OFS) begin
              ent_stage = ddc_pkg::ST_RESTART;
              ent_sub   = ddc_pkg::SB_WAIT;
            end else begin
              bit_counter_next = 3'd7;
              shift_next       = '0;
              bytes_done_next  = '0;
              ent_stage        = ddc_pkg::ST_RECV;
              ent_sub          = ddc_pkg::SB_FIRST;
            end
          end
        end else begin
          ent = 1'b1;
        end
      end else if (stage == ddc_pkg::ST_RECV) begin
        ent = 1'b1;
        if (sub == ddc_pkg::SB_RECV_END) begin
          if (bit_counter != 3'd0) begin
            bit_counter_next = bit_counter - 3'd1;
            ent_sub          = ddc_pkg::SB_FIRST;
          end
        end else if (sub == ddc_pkg::SB_LAST) begin
          if (last_cur) begin
            ent_stage = ddc_pkg::ST_STOP;
          end else begin
            bytes_done_next  = bytes_done + BW'(1);
            bit_counter_next = 3'd7;
            shift_next       = '0;
          end
          ent_sub = ddc_pkg::SB_FIRST;
        end
      end else begin
        // stop condition
        if (sub < ddc_pkg::SB_STOP_END) begin
          ent = 1'b1;
        end else begin
          stage_next = ddc_pkg::ST_IDLE;
          sub_next   = '0;
        end
      end
    end

    // actions on entering a substep
    if (ent) begin
      stage_next = ent_stage;
      sub_next   = ent_sub;
      phase_next = phase_load;
      unique case (ent_stage)
        ddc_pkg::ST_IDLE: ;
        ddc_pkg::ST_WAKE, ddc_pkg::ST_RESTART: begin
          priority if (ent_stage == ddc_pkg::ST_WAKE && ent_sub == 3'd0) clock_low_next = 1'b0;
          else if (ent_stage == ddc_pkg::ST_WAKE && ent_sub == 3'd2) clock_low_next = 1'b1;
          else if (ent_sub == 3'd3) clock_low_next = 1'b1;
          else if (ent_sub == 3'd4) data_low_next = 1'b0;
          else if (ent_sub == 3'd5 || ent_sub == 3'd7) clock_low_next = 1'b0;
          else if (ent_sub == 3'd6) data_low_next = 1'b1;
          else ;
        end
        ddc_pkg::ST_SEND_W, ddc_pkg::ST_SEND_OFS, ddc_pkg::ST_SEND_R: begin
          priority if (ent_sub == 3'd0 || ent_sub == 3'd3) clock_low_next = 1'b1;
          else if (ent_sub == 3'd1) data_low_next = ~send_byte[bit_counter_next];
          else if (ent_sub == 3'd2 || ent_sub == 3'd5) clock_low_next = 1'b0;
          else if (ent_sub == 3'd4) data_low_next = 1'b0;
          else ;
        end
        ddc_pkg::ST_RECV: begin
          priority if (ent_sub == 3'd0 || ent_sub == 3'd4 || ent_sub == 3'd5) begin
            clock_low_next = 1'b1;
          end else if (ent_sub == 3'd1) begin
            data_low_next = 1'b0;
          end else if (ent_sub == 3'd2 || ent_sub == 3'd7) begin
            clock_low_next = 1'b0;
          end else if (ent_sub == 3'd3) begin
            stretch_next = '0;
            phase_next   = '0;
          end else begin
            // acknowledge all but the last byte
            data_low_next = !last_nxt;
          end
        end
        ddc_pkg::ST_STOP: begin
          priority if (ent_sub == 3'd0) clock_low_next = 1'b1;
          else if (ent_sub == 3'd1) data_low_next = 1'b1;
          else if (ent_sub == 3'd3) data_low_next = 1'b0;
          else clock_low_next = 1'b0;
        end
      endcase
    end
  end

  // result fields for this tick
  always_comb begin : outputs
    res            = '0;
    res.scl_low    = clock_low_next;
    res.sda_low    = data_low_next;
    res.busy_res   = stage_next != ddc_pkg::ST_IDLE;
    if (step && phase_end && stage == ddc_pkg::ST_RECV && sub == ddc_pkg::SB_LAST) begin
      res.byte_valid = 1'b1;
      res.byte_data  = shift_byte;
      res.byte_index = ddc_pkg::BYTE_W'(bytes_done);
      res.last_byte  = last_cur;
    end
    if (step && phase_end && is_send && sub == ddc_pkg::SB_LAST && sda_in) begin
      res.done_res  = 1'b1;
      res.nak_error = 1'b1;
    end
    if (step && phase_end && stage == ddc_pkg::ST_STOP && sub >= ddc_pkg::SB_STOP_END) begin
      res.done_res = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= ddc_pkg::ST_IDLE;
      sub           <= '0;
      phase_timer   <= '0;
      stretch_timer <= '0;
      bit_counter   <= 3'd7;
      bytes_done    <= '0;
      shift_byte    <= '0;
      clock_low     <= 1'b0;
      data_low      <= 1'b0;
    end else begin
      stage         <= stage_next;
      sub           <= sub_next;
      phase_timer   <= phase_next;
      stretch_timer <= stretch_next;
      bit_counter   <= bit_counter_next;
      bytes_done    <= bytes_done_next;
      shift_byte    <= shift_next;
      clock_low     <= clock_low_next;
      data_low      <= data_low_next;
    end
  end

  // checks
  `ASSERT_CLK(a_nak_ends, res.nak_error |-> res.done_res && !res.busy_res, "nak without end")
  `ASSERT_CLK(a_idle_tick, step && stage == ddc_pkg::ST_IDLE && !action |=> stage == ddc_pkg::ST_IDLE && !clock_low && !data_low, "idle tick changed state")
  `ASSERT_NEVER(a_wait_timer, stage == ddc_pkg::ST_RECV && sub == ddc_pkg::SB_WAIT && phase_timer != '0, "phase timer running in stretch wait")
  `ASSERT_CLK(a_last_stop, res.last_byte |=> stage == ddc_pkg::ST_STOP && sub == ddc_pkg::SB_FIRST, "last byte not followed by stop")

endmodule

@@ design/ddc_edid_i2c_reader.sv @@
// ----------------------------------------------------------------------------
// ddc_edid_i2c_reader
// Bit-level I2C master reading a display's EDID over DDC, one tick per item
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one tick per transaction: s_tuser = 1 begins a transfer
//   (ignored while busy), s_tuser = 0 is a plain time tick; s_tdata holds
//   the sampled scl and sda wire levels.
//   m_* returns exactly one result per tick: wire drives, a received byte
//   with its index (m_tlast on the final byte), done, nak and busy flags.
//   cfg_* writes the five registers; write only while no tick is in flight.
// Path: a tick passes the input register, then the result register.
// Throughput: one tick per clock unless stalled; the sequencer step is one
//   register stage of short logic between the input and result registers.
// Reset: registers return to defaults, the bus is released, the sequencer
//   idles, and both stream registers are emptied.
// Stall: with m_tready low the result register holds and the input register
//   fills, after which s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddc_edid_i2c_reader #(
  parameter int MAX_BYTES   = ddc_pkg::MAX_BYTES_DEF,
  parameter int TIMER_WIDTH = ddc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // tick stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [0] scl_in, [1] sda_in
  input  logic                        s_tuser,   // [0] action
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,   // [0] scl_low, [1] sda_low,
                                                 // [2] byte_valid, [10:3] byte_data,
                                                 // [18:11] byte_index, [19] done_res,
                                                 // [20] nak_error, [21] busy_res
  output logic                        m_tlast,   // last_byte
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ddc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ddc_pkg::CDATA_W-1:0] cfg_data
);

  ddc_pkg::cfg_t cfg;
  ddc_pkg::res_t res, res_q;

  logic in_valid;
  logic in_action;
  logic in_scl;
  logic in_sda;
  logic out_free;
  logic advance;

  assign cfg_ready = 1'b1;

  ddc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake flow
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_scl    <= s_tdata[0];
      in_sda    <= s_tdata[1];
    end
  end

  ddc_seq #(
    .MAX_BYTES   (MAX_BYTES),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .action (in_action),
    .scl_in (in_scl),
    .sda_in (in_sda),
    .cfg    (cfg),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  // result packing
  assign m_tdata = {2'b00, res_q.busy_res, res_q.nak_error, res_q.done_res,
                    res_q.byte_index, res_q.byte_data, res_q.byte_valid,
                    res_q.sda_low, res_q.scl_low};
  assign m_tlast = res_q.last_byte;

  // checks
  `ASSERT_CLK(a_in_taken, s_tvalid && s_tready |=> in_valid, "accepted tick not registered")
  `ASSERT_CLK(a_out_loaded, advance |=> m_tvalid, "stepped tick gave no result")
  `ASSERT_CLK(a_in_held, in_valid && !out_free |=> in_valid && $stable(in_action), "pending tick lost")

endmodule
